@@ design/dirty_rectangle_tracker_core_defines.svh @@
// Assertion macros for the checker file of the dirty rectangle tracker.
// No dependencies; included by design/drt_checker.sv.
`ifndef DIRTY_RECTANGLE_TRACKER_CORE_DEFINES_SVH
`define DIRTY_RECTANGLE_TRACKER_CORE_DEFINES_SVH

// Plain property, sampled on clk, off during reset.
`define DRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A stalled beat keeps valid and payload.
`define DRT_ASSERT_HOLD(lbl, vld, rdy, dat, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (vld && !rdy) |=> (vld && $stable(dat))) else $error(msg);

`endif

@@ design/drt_pkg.sv @@
// Types, constants and helpers of the dirty rectangle tracker.
// No dependencies; used by drt_front, drt_back and the top module.
package drt_pkg;

  localparam int XW              = 15;  // stored coordinate width
  localparam int SZW             = 30;  // area of one rectangle
  localparam int TOTW            = 36;  // pixel total
  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_COORD_BITS  = 16;
  localparam logic [XW-1:0] RST_WIDTH  = 15'd480;
  localparam logic [XW-1:0] RST_HEIGHT = 15'd320;

  // register select (paddr bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_INV = 2'd0,
    OP_CLR = 2'd1,
    OP_REF = 2'd2
  } op_t;

  typedef struct packed {
    logic [XW-1:0] x1;
    logic [XW-1:0] y1;
    logic [XW-1:0] x2;
    logic [XW-1:0] y2;
  } rect_t;

  typedef struct packed {
    op_t   op;
    rect_t r;
  } cmd_t;

  typedef struct packed {
    rect_t           r;
    logic            area_valid;
    logic            last;
    logic [TOTW-1:0] total;
  } res_t;

  function automatic logic [SZW-1:0] rect_area(rect_t a);
    logic [XW:0]     dx;
    logic [XW:0]     dy;
    logic [2*XW+1:0] p;
    dx = {1'b0, a.x2} - {1'b0, a.x1} + (XW+1)'(1);
    dy = {1'b0, a.y2} - {1'b0, a.y1} + (XW+1)'(1);
    p  = dx * dy;
    return p[SZW-1:0];
  endfunction

endpackage

@@ design/drt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drt_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ design/drt_front.sv @@
// Front end: clips invalidate rectangles, drops empty and unknown items,
// queues commands for the back end in a two-entry queue. Uses drt_pkg.
module drt_front #(
  parameter int COORD_BITS = drt_pkg::DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_func,
  input  logic signed [COORD_BITS-1:0] in_left,
  input  logic signed [COORD_BITS-1:0] in_top,
  input  logic signed [COORD_BITS-1:0] in_right,
  input  logic signed [COORD_BITS-1:0] in_bottom,
  input  logic [drt_pkg::XW-1:0]       scr_w,
  input  logic [drt_pkg::XW-1:0]       scr_h,
  output logic                         q_valid,
  input  logic                         q_ready,
  output drt_pkg::cmd_t                q_cmd
);
  import drt_pkg::*;

  localparam int SW = (COORD_BITS > 16 ? COORD_BITS : 16) + 1;

  logic signed [SW-1:0] wm1, hm1, l_s, t_s, r_s, b_s, x1, y1, x2, y2;
  logic                 keep, push, pop;
  cmd_t                 cmd_in;
  cmd_t                 fifo [2];
  logic                 wptr, rptr;
  logic [1:0]           fill;

  always_comb begin
    wm1 = $signed({{(SW-XW){1'b0}}, scr_w}) - SW'(1);
    hm1 = $signed({{(SW-XW){1'b0}}, scr_h}) - SW'(1);
    l_s = SW'(in_left);
    t_s = SW'(in_top);
    r_s = SW'(in_right);
    b_s = SW'(in_bottom);
    x1  = (l_s < 0) ? '0 : l_s;
    y1  = (t_s < 0) ? '0 : t_s;
    x2  = (r_s < wm1) ? r_s : wm1;
    y2  = (b_s < hm1) ? b_s : hm1;
    cmd_in.op   = op_t'(in_func);
    cmd_in.r.x1 = x1[XW-1:0];
    cmd_in.r.y1 = y1[XW-1:0];
    cmd_in.r.x2 = x2[XW-1:0];
    cmd_in.r.y2 = y2[XW-1:0];
    keep = ((in_func == OP_INV) && (x1 <= x2) && (y1 <= y2)) ||
           (in_func == OP_CLR) || (in_func == OP_REF);
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = fifo[rptr];
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= cmd_in;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ design/drt_back.sv @@
// Back end: sequencer over the rectangle table (append scan, merge, emit)
// with the result output register. Uses drt_pkg and drt_ram.
module drt_back #(
  parameter int TABLE_DEPTH = drt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [drt_pkg::XW-1:0] scr_w,
  input  logic [drt_pkg::XW-1:0] scr_h,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  drt_pkg::cmd_t          q_cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output drt_pkg::res_t          out_res
);
  import drt_pkg::*;

  localparam int IW   = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_MT_RD, ST_MT_LD, ST_MS_RD, ST_MS_BOX,
    ST_MS_MUL, ST_MS_CMP, ST_EM_RD, ST_EM_SZ, ST_EM_OUT, ST_MARK
  } state_t;

  state_t           state;
  logic [CNTW-1:0]  cnt, idx, sidx;
  logic             rd_vld, rd_last;
  logic [TABLE_DEPTH-1:0] flags, rem;
  cmd_t             cur;
  rect_t            tgt, box, scr, rd_r;
  logic [SZW-1:0]   tgt_sz, box_sz, src_sz, em_sz;
  logic [TOTW-1:0]  total, total_sum;
  logic             out_free, out_load, hit, touch, is_last, full;

  logic             we, re;
  logic [IW-1:0]    waddr, raddr;
  rect_t            wdata;
  logic [$bits(rect_t)-1:0] rdata;

  drt_ram #(.WIDTH($bits(rect_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    rd_r  = rect_t'(rdata);
    scr   = '{x1: '0, y1: '0, x2: scr_w - XW'(1), y2: scr_h - XW'(1)};
    full  = (cnt == CNTW'(TABLE_DEPTH));
    hit   = (cur.r.x1 >= rd_r.x1) && (cur.r.y1 >= rd_r.y1) &&
            (cur.r.x2 <= rd_r.x2) && (cur.r.y2 <= rd_r.y2);
    touch = (tgt.x1 <= rd_r.x2) && (tgt.x2 >= rd_r.x1) &&
            (tgt.y1 <= rd_r.y2) && (tgt.y2 >= rd_r.y1);
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      rem[j] = !flags[j] && (CNTW'(j) < cnt) && (CNTW'(j) > idx);
    end
    is_last   = (rem == '0);
    total_sum = total + TOTW'(em_sz);
    out_free  = !out_valid || out_ready;
    out_load  = out_free && (state inside {ST_EM_OUT, ST_MARK});
    q_ready   = (state == ST_IDLE);
  end

  // table port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = cur.r;
    re    = 1'b0;
    raddr = '0;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_cmd.op == OP_INV && cnt == '0) begin
          we    = 1'b1;
          wdata = q_cmd.r;
        end
      end
      ST_SCAN: begin
        if (rd_vld && !hit && rd_last) begin
          we    = 1'b1;
          waddr = full ? '0 : cnt[IW-1:0];
          wdata = full ? scr : cur.r;
        end else if (!(rd_vld && hit) && idx < cnt) begin
          re    = 1'b1;
          raddr = idx[IW-1:0];
        end
      end
      ST_MT_RD, ST_EM_RD: begin
        if (idx < cnt && !flags[idx[IW-1:0]]) begin
          re    = 1'b1;
          raddr = idx[IW-1:0];
        end
      end
      ST_MS_RD: begin
        if (sidx == cnt) begin
          we    = 1'b1;
          waddr = idx[IW-1:0];
          wdata = tgt;
        end else if (!flags[sidx[IW-1:0]] && sidx != idx) begin
          re    = 1'b1;
          raddr = sidx[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      idx       <= '0;
      sidx      <= '0;
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      flags     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur    <= q_cmd;
            idx    <= '0;
            rd_vld <= 1'b0;
            case (q_cmd.op)
              OP_INV:  if (cnt == '0) cnt <= CNTW'(1); else state <= ST_SCAN;
              OP_CLR:  cnt <= '0;
              OP_REF:  state <= (cnt == '0) ? ST_MARK : ST_MT_RD;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_vld && hit) begin
            state <= ST_IDLE;
          end else if (rd_vld && rd_last) begin
            cnt   <= full ? CNTW'(1) : cnt + CNTW'(1);
            state <= ST_IDLE;
          end else if (idx < cnt) begin
            rd_vld  <= 1'b1;
            rd_last <= (idx == cnt - CNTW'(1));
            idx     <= idx + CNTW'(1);
          end
        end
        ST_MT_RD: begin
          if (idx == cnt) begin
            idx   <= '0;
            state <= ST_EM_RD;
          end else if (flags[idx[IW-1:0]]) begin
            idx <= idx + CNTW'(1);
          end else begin
            state <= ST_MT_LD;
          end
        end
        ST_MT_LD: begin
          tgt    <= rd_r;
          tgt_sz <= rect_area(rd_r);
          sidx   <= '0;
          state  <= ST_MS_RD;
        end
        ST_MS_RD: begin
          if (sidx == cnt) begin
            idx   <= idx + CNTW'(1);
            state <= ST_MT_RD;
          end else if (flags[sidx[IW-1:0]] || sidx == idx) begin
            sidx <= sidx + CNTW'(1);
          end else begin
            state <= ST_MS_BOX;
          end
        end
        ST_MS_BOX: begin
          if (touch) begin
            box.x1 <= (tgt.x1 < rd_r.x1) ? tgt.x1 : rd_r.x1;
            box.y1 <= (tgt.y1 < rd_r.y1) ? tgt.y1 : rd_r.y1;
            box.x2 <= (tgt.x2 > rd_r.x2) ? tgt.x2 : rd_r.x2;
            box.y2 <= (tgt.y2 > rd_r.y2) ? tgt.y2 : rd_r.y2;
            state  <= ST_MS_MUL;
          end else begin
            sidx  <= sidx + CNTW'(1);
            state <= ST_MS_RD;
          end
        end
        ST_MS_MUL: begin
          box_sz <= rect_area(box);
          src_sz <= rect_area(rd_r);
          state  <= ST_MS_CMP;
        end
        ST_MS_CMP: begin
          if ({1'b0, box_sz} < ({1'b0, tgt_sz} + {1'b0, src_sz})) begin
            tgt                 <= box;
            tgt_sz              <= box_sz;
            flags[sidx[IW-1:0]] <= 1'b1;
          end
          sidx  <= sidx + CNTW'(1);
          state <= ST_MS_RD;
        end
        ST_EM_RD: begin
          if (idx == cnt) begin
            cnt   <= '0;
            flags <= '0;
            total <= '0;
            state <= ST_IDLE;
          end else if (flags[idx[IW-1:0]]) begin
            idx <= idx + CNTW'(1);
          end else begin
            state <= ST_EM_SZ;
          end
        end
        ST_EM_SZ: begin
          em_sz <= rect_area(rd_r);
          state <= ST_EM_OUT;
        end
        ST_EM_OUT: begin
          if (out_free) begin
            out_res.r          <= rd_r;
            out_res.area_valid <= 1'b1;
            out_res.last       <= is_last;
            out_res.total      <= is_last ? total_sum : '0;
            total              <= total_sum;
            idx                <= idx + CNTW'(1);
            state              <= ST_EM_RD;
          end
        end
        ST_MARK: begin
          if (out_free) begin
            out_res   <= '{r: '0, area_valid: 1'b0, last: 1'b1, total: '0};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ design/dirty_rectangle_tracker_core.sv @@
// Dirty rectangle tracker: stream in, stream out, APB register port.
// Uses drt_pkg, drt_front, drt_back (and drt_ram below it).
//
// Usage:
//   Input beats (s_*): tuser = func (0 invalidate, 1 clear, 2 refresh),
//   tdata = left, top, right, bottom, signed COORD_BITS each.
//   Output beats (m_*): one per emitted rectangle of a refresh, tlast on the
//   final one, which also carries the pixel total. A refresh of an empty
//   table gives a single beat with tuser = 0 and tlast = 1.
//   Registers: 0x0 screen width, 0x4 screen height (15 bits, 480 x 320 after
//   reset). Write them only while the block is idle.
// Operation:
//   The front end clips in the accept cycle and queues up to two commands,
//   so input is taken while the back end is busy or the output is stalled.
//   The back end walks the table through its single read port: invalidate
//   scans the stored rectangles, clear empties the table; refresh checks
//   pairs (read, bounding box, multiply, compare), merges where that saves
//   area, then reads, sizes and outputs each rectangle that is left.
//   A stalled receiver holds the result register; the back end waits on it.
// Reset: table emptied, queue flushed, screen registers back to defaults.
module dirty_rectangle_tracker_core #(
  parameter int TABLE_DEPTH = drt_pkg::DEF_TABLE_DEPTH,
  parameter int COORD_BITS  = drt_pkg::DEF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata, // left, top, right, bottom
  input  logic [1:0]  s_tuser,                       // func
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,  // out_left, out_top, out_right, out_bottom, total_pixels
  output logic        m_tuser,  // area_valid
  output logic        m_tlast,  // last
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import drt_pkg::*;

  logic [XW-1:0] scr_w, scr_h;
  logic          q_valid, q_ready;
  cmd_t          q_cmd;
  res_t          res;

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {17'b0, scr_h} : {17'b0, scr_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= RST_WIDTH;
      scr_h <= RST_HEIGHT;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_WIDTH) scr_w <= pwdata[XW-1:0];
      else                       scr_h <= pwdata[XW-1:0];
    end
  end

  drt_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_func(s_tuser),
    .in_left  ($signed(s_tdata[COORD_BITS-1:0])),
    .in_top   ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
    .in_right ($signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .in_bottom($signed(s_tdata[4*COORD_BITS-1:3*COORD_BITS])),
    .scr_w(scr_w), .scr_h(scr_h),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  drt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .scr_w(scr_w), .scr_h(scr_h),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {res.total, res.r.y2, res.r.x2, res.r.y1, res.r.x1};
  assign m_tuser = res.area_valid;
  assign m_tlast = res.last;
endmodule

@@ design/drt_checker.sv @@
// Port-level checks on the result stream of the tracker, bound to the top.
// Depends on dirty_rectangle_tracker_core_defines.svh.
`include "dirty_rectangle_tracker_core_defines.svh"

module drt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  `DRT_ASSERT_HOLD(a_hold, m_tvalid, m_tready, {m_tdata, m_tuser, m_tlast}, "beat dropped")
  `DRT_ASSERT(a_empty_last, (m_tvalid && !m_tuser) |-> m_tlast, "empty marker not last")
  `DRT_ASSERT(a_empty_zero, (m_tvalid && !m_tuser) |-> (m_tdata == '0), "empty marker data")
  `DRT_ASSERT(a_total_last, (m_tvalid && !m_tlast) |-> (m_tdata[95:60] == '0), "early total")
endmodule

bind dirty_rectangle_tracker_core drt_checker u_drt_checker (.*);
